FILE: rtl/mwo_pkg.sv
// ----------------------------------------------------------------------------
// mwo_pkg - shared definitions for the multi-waveform oscillator
// widths, register indexes, waveform codes, sequencer states and the
// fixed-point quarter-sine series used to build the sine table
// ----------------------------------------------------------------------------
package mwo_pkg;

  localparam int unsigned MWO_SINE_DEPTH = 1024;
  localparam int unsigned MWO_PHASE_BITS = 32;

  localparam int SAMPLE_W = 24;
  localparam int STEP_W   = 32;
  localparam int DUTY_W   = 16;
  localparam int WAVE_W   = 3;
  localparam int REG_IDX_W  = 2;
  localparam int REG_DATA_W = 32;

  // register indexes
  localparam logic [REG_IDX_W-1:0] REG_WAVE_SELECT = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_PHASE_STEP  = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_DUTY        = 2'd2;
  localparam logic [REG_IDX_W-1:0] REG_DC_LEVEL    = 2'd3;

  // waveform codes
  localparam logic [WAVE_W-1:0] WAVE_SINE     = 3'd0;
  localparam logic [WAVE_W-1:0] WAVE_COSINE   = 3'd1;
  localparam logic [WAVE_W-1:0] WAVE_TRIANGLE = 3'd2;
  localparam logic [WAVE_W-1:0] WAVE_SQUARE   = 3'd3;
  localparam logic [WAVE_W-1:0] WAVE_SAWTOOTH = 3'd4;
  localparam logic [WAVE_W-1:0] WAVE_DC       = 3'd5;
  localparam logic [WAVE_W-1:0] WAVE_NOISE    = 3'd6;
  localparam logic [WAVE_W-1:0] WAVE_SILENT   = 3'd7;

  localparam logic [DUTY_W-1:0] DUTY_MIN  = 16'd66;
  localparam logic [DUTY_W-1:0] DUTY_MAX  = 16'd65470;
  localparam logic [DUTY_W-1:0] DUTY_HALF = 16'd32768;
  localparam logic [DUTY_W-1:0] DUTY_RESET = 16'd32768;

  localparam logic [31:0] LFSR_MASK  = 32'h8020_0003;
  localparam logic [31:0] LFSR_RESET = 32'h0000_0001;

  localparam logic signed [25:0] Q23_MAX = 26'sd8388607;
  localparam logic signed [25:0] Q23_MIN = -26'sd8388608;
  localparam logic signed [25:0] Q23_ONE = 26'sd8388608;

  // triangle divider: quotient never exceeds 2^24, so 25 quotient bits
  localparam int DIV_STEPS = 25;
  localparam int DIV_NUM_W = 57;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);

  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
  localparam logic [63:0] ONE_Q30     = 64'd1 << 30;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SETUP,
    ST_DIVIDE,
    ST_RESULT
  } mwo_state_t;

  // sin(x) for x in Q2.30 radians, result Q1.23 rounded and saturated
  // nested taylor terms, innermost first
  function automatic logic [SAMPLE_W-1:0] sine_poly(input logic [63:0] x);
    logic [63:0] x2;
    logic [63:0] t;
    logic [63:0] s;
    x2 = (x * x) >> 30;
    t  = ONE_Q30;
    t  = ONE_Q30 - (((x2 * t) >> 30) / 64'd210);
    t  = ONE_Q30 - (((x2 * t) >> 30) / 64'd156);
    t  = ONE_Q30 - (((x2 * t) >> 30) / 64'd110);
    t  = ONE_Q30 - (((x2 * t) >> 30) / 64'd72);
    t  = ONE_Q30 - (((x2 * t) >> 30) / 64'd42);
    t  = ONE_Q30 - (((x2 * t) >> 30) / 64'd20);
    t  = ONE_Q30 - (((x2 * t) >> 30) / 64'd6);
    s = (x * t) >> 30;
    s = (s + 64'd64) >> 7;
    if (s > 64'd8388607) begin
      s = 64'd8388607;
    end
    return s[SAMPLE_W-1:0];
  endfunction

endpackage

FILE: rtl/mwo_if.sv
// ----------------------------------------------------------------------------
// mwo channel interfaces
// tick, sample and register write channels, each with valid and ready
// ----------------------------------------------------------------------------
interface mwo_tick_if import mwo_pkg::*; ();
  logic valid;
  logic ready;
  logic clear_phase;

  modport source (output valid, output clear_phase, input ready);
  modport sink   (input valid, input clear_phase, output ready);
endinterface

interface mwo_sample_if import mwo_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

interface mwo_cfg_if import mwo_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [REG_IDX_W-1:0]  index;
  logic [REG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: rtl/multi_waveform_oscillator.sv
// ----------------------------------------------------------------------------
// multi_waveform_oscillator - direct digital synthesis oscillator
// phase accumulator with sine, cosine, triangle, square, sawtooth, dc and
// noise outputs in signed Q1.23
// ----------------------------------------------------------------------------
// Each tick item advances the phase accumulator by phase_step (after an
// optional clear) and yields one Q1.23 sample item of the selected waveform.
// The block works on one tick at a time: sine, cosine, square, sawtooth, dc,
// noise and silent go from acceptance to the sample register through the
// accept, set-up (with the registered sine table read) and result states;
// the triangle adds a divide state, since its slope division runs through a
// restoring divider with one quotient bit per cycle. The sample sits in an
// output register, so the next tick is taken while an earlier sample still
// waits for its sink; a stalled sink only holds the result cycle until the
// register frees. The sine table is a constant quarter-wave rom built at
// elaboration, so no fill pass follows reset. Register writes are always
// ready and are to be made only while no tick is in flight.
// ----------------------------------------------------------------------------
module multi_waveform_oscillator import mwo_pkg::*; #(
  parameter int unsigned SINE_TABLE_DEPTH = MWO_SINE_DEPTH,
  parameter int unsigned PHASE_BITS       = MWO_PHASE_BITS
) (
  input  logic      clk,
  input  logic      rst,
  mwo_tick_if.sink     tick,
  mwo_sample_if.source samples,
  mwo_cfg_if.sink      cfg
);

  localparam int AW = $clog2(SINE_TABLE_DEPTH);   // rom address bits
  localparam int KW = AW + 1;                     // index before clamp
  localparam int FW = PHASE_BITS - 2;             // phase bits within a quadrant
  localparam int PW = FW + KW;                    // index product width

  // number of half steps across the quarter wave
  localparam logic [63:0] ROM_DEN = 64'(2 * SINE_TABLE_DEPTH);

  typedef logic [SAMPLE_W-1:0] rom_t [SINE_TABLE_DEPTH];

  // quarter sine at the middle of each of the table's steps
  function automatic rom_t build_rom();
    rom_t        r;
    logic [63:0] x;
    for (int i = 0; i < SINE_TABLE_DEPTH; i++) begin
      x = (HALF_PI_Q30 * 64'(2 * i + 1)) / ROM_DEN;
      r[i] = sine_poly(x);
    end
    return r;
  endfunction

  localparam rom_t SINE_ROM = build_rom();

  // configuration registers
  logic [WAVE_W-1:0]          wave_select;
  logic [STEP_W-1:0]          phase_step;
  logic [DUTY_W-1:0]          duty_fraction;
  logic signed [SAMPLE_W-1:0] dc_level;

  // oscillator state
  logic [PHASE_BITS-1:0] phase_acc;
  logic [31:0]           noise_lfsr;
  mwo_state_t            state, state_next;

  // divider registers
  logic [31:0]          rem;
  logic [DIV_STEPS-1:0] quo;
  logic [31:0]          divisor;
  logic                 falling;
  logic [DIV_CNT_W-1:0] div_cnt;

  // sine rom read data, output register
  logic [SAMPLE_W-1:0]        rom_q;
  logic                       out_valid;
  logic signed [SAMPLE_W-1:0] out_sample;

  // combinational signals
  logic [PHASE_BITS-1:0] step_ext;
  logic [31:0]           phase_q32;
  logic                  tick_take;
  logic                  load_out;
  logic [DUTY_W-1:0]     duty;
  logic [31:0]           duty_q32;
  logic [31:0]           rise_len;
  logic                  on_fall;
  logic [DIV_NUM_W-1:0]  numer;
  logic [32:0]           div_shift;
  logic [32:0]           div_diff;
  logic                  div_ge;
  logic [1:0]            quad;
  logic [FW-1:0]         frac;
  logic [PW-1:0]         idx_prod;
  logic [KW-1:0]         idx_full;
  logic [AW-1:0]         idx;
  logic [AW-1:0]         rom_addr;
  logic [31:0]           lfsr_next;
  logic signed [25:0]    saw_val;
  logic signed [25:0]    wave_val;
  logic signed [SAMPLE_W-1:0] sat_val;

  // phase step and 32-bit view of the phase, whatever the accumulator width
  if (PHASE_BITS >= 32) begin : g_wide_phase
    assign step_ext  = PHASE_BITS'(phase_step);
    assign phase_q32 = phase_acc[PHASE_BITS-1 -: 32];
  end else begin : g_narrow_phase
    assign step_ext  = phase_step[PHASE_BITS-1:0];
    assign phase_q32 = {phase_acc, {(32 - PHASE_BITS){1'b0}}};
  end

  assign tick_take = tick.valid && tick.ready;

  // duty clamped to 0.001 .. 0.999, then as a Q0.32 fraction of a turn
  always_comb begin
    duty = duty_fraction;
    if (duty_fraction < DUTY_MIN) begin
      duty = DUTY_MIN;
    end else if (duty_fraction > DUTY_MAX) begin
      duty = DUTY_MAX;
    end
  end
  assign duty_q32 = {duty, 16'h0000};
  assign rise_len = 32'h0 - duty_q32;   // length of the falling slope

  // triangle numerator: phase over the slope, rounded half up
  assign on_fall = (phase_q32 <= rise_len);
  always_comb begin
    if (on_fall) begin
      numer = (DIV_NUM_W'(phase_q32) << 24) + DIV_NUM_W'(rise_len >> 1);
    end else begin
      numer = (DIV_NUM_W'(phase_q32 - rise_len) << 24) + DIV_NUM_W'(duty_q32 >> 1);
    end
  end

  // one restoring divider step
  assign div_shift = {rem, quo[DIV_STEPS-1]};
  assign div_ge    = (div_shift >= {1'b0, divisor});
  assign div_diff  = div_shift - {1'b0, divisor};

  // quarter-wave table address; cosine is a quarter turn ahead
  assign quad     = phase_acc[PHASE_BITS-1 -: 2] + 2'((wave_select == WAVE_COSINE) ? 1 : 0);
  assign frac     = phase_acc[FW-1:0];
  assign idx_prod = PW'(frac) * PW'(SINE_TABLE_DEPTH);
  assign idx_full = idx_prod[PW-1 -: KW];
  assign idx      = (idx_full >= KW'(SINE_TABLE_DEPTH)) ? AW'(SINE_TABLE_DEPTH - 1)
                                                        : idx_full[AW-1:0];
  assign rom_addr = quad[0] ? (AW'(SINE_TABLE_DEPTH - 1) - idx) : idx;

  // galois lfsr, one shift to the right
  assign lfsr_next = {1'b0, noise_lfsr[31:1]} ^ (noise_lfsr[0] ? LFSR_MASK : 32'h0);

  // sample of the selected waveform, wide enough for +1.0 before saturation
  assign saw_val = $signed({2'b00, phase_q32[31:8]}) - Q23_ONE;
  always_comb begin
    case (wave_select)
      WAVE_SINE, WAVE_COSINE: begin
        wave_val = quad[1] ? -$signed({2'b00, rom_q}) : $signed({2'b00, rom_q});
      end
      WAVE_TRIANGLE: begin
        wave_val = falling ? (Q23_ONE - $signed({1'b0, quo}))
                           : ($signed({1'b0, quo}) - Q23_ONE);
      end
      WAVE_SQUARE: begin
        wave_val = (phase_q32 < duty_q32) ? Q23_MAX : Q23_MIN;
      end
      WAVE_SAWTOOTH: begin
        wave_val = (duty < DUTY_HALF) ? -saw_val : saw_val;
      end
      WAVE_DC: begin
        wave_val = 26'(dc_level);
      end
      WAVE_NOISE: begin
        wave_val = 26'($signed(noise_lfsr[SAMPLE_W-1:0]));
      end
      default: begin
        wave_val = '0;
      end
    endcase
  end

  always_comb begin
    if (wave_val > Q23_MAX) begin
      sat_val = Q23_MAX[SAMPLE_W-1:0];
    end else if (wave_val < Q23_MIN) begin
      sat_val = Q23_MIN[SAMPLE_W-1:0];
    end else begin
      sat_val = wave_val[SAMPLE_W-1:0];
    end
  end

  // sequencer
  always_comb begin
    state_next = state;
    tick.ready = 1'b0;
    load_out   = 1'b0;
    case (state)
      ST_IDLE: begin
        tick.ready = 1'b1;
        if (tick.valid) begin
          state_next = ST_SETUP;
        end
      end
      ST_SETUP: begin
        state_next = (wave_select == WAVE_TRIANGLE) ? ST_DIVIDE : ST_RESULT;
      end
      ST_DIVIDE: begin
        if (div_cnt == DIV_CNT_W'(DIV_STEPS - 1)) begin
          state_next = ST_RESULT;
        end
      end
      ST_RESULT: begin
        // wait for the output register to free
        if (!out_valid || samples.ready) begin
          load_out   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // control state, configuration, phase accumulator, lfsr and the output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      wave_select   <= WAVE_SINE;
      phase_step    <= '0;
      duty_fraction <= DUTY_RESET;
      dc_level      <= '0;
      phase_acc     <= '0;
      noise_lfsr    <= LFSR_RESET;
      out_valid     <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg.valid && cfg.ready) begin
        case (cfg.index)
          REG_WAVE_SELECT: wave_select   <= cfg.data[WAVE_W-1:0];
          REG_PHASE_STEP:  phase_step    <= cfg.data[STEP_W-1:0];
          REG_DUTY:        duty_fraction <= cfg.data[DUTY_W-1:0];
          REG_DC_LEVEL:    dc_level      <= $signed(cfg.data[SAMPLE_W-1:0]);
          default: ;
        endcase
      end
      if (tick_take) begin
        phase_acc <= (tick.clear_phase ? '0 : phase_acc) + step_ext;
      end
      // the lfsr only moves on noise ticks
      if (state == ST_SETUP && wave_select == WAVE_NOISE) begin
        noise_lfsr <= lfsr_next;
      end
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (samples.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // divider datapath and output sample
  always_ff @(posedge clk) begin
    if (state == ST_SETUP) begin
      rem     <= numer[DIV_NUM_W-1 -: 32];
      quo     <= numer[DIV_STEPS-1:0];
      divisor <= on_fall ? rise_len : duty_q32;
      falling <= on_fall;
      div_cnt <= '0;
    end else if (state == ST_DIVIDE) begin
      rem     <= div_ge ? div_diff[31:0] : div_shift[31:0];
      quo     <= {quo[DIV_STEPS-2:0], div_ge};
      div_cnt <= div_cnt + 1'b1;
    end
    if (load_out) begin
      out_sample <= sat_val;
    end
  end

  // sine rom, registered read
  always_ff @(posedge clk) begin
    rom_q <= SINE_ROM[rom_addr];
  end

  assign samples.valid  = out_valid;
  assign samples.sample = out_sample;
  assign cfg.ready      = 1'b1;

endmodule

FILE: rtl/mwo_checker.sv
// ----------------------------------------------------------------------------
// mwo_checker - port-level checks for the oscillator
// tick spacing, sample origin, output hold and write readiness, bound to the top level
// ----------------------------------------------------------------------------
module mwo_checker import mwo_pkg::*; (
  input logic                clk,
  input logic                rst,
  input logic                tick_valid,
  input logic                tick_ready,
  input logic                out_valid,
  input logic                out_ready,
  input logic [SAMPLE_W-1:0] out_sample,
  input logic                cfg_ready
);

  // a tick keeps the sequencer busy through its set-up and result states
  a_tick_busy: assert property (@(posedge clk) disable iff (rst)
    tick_valid && tick_ready |=> !tick_ready ##1 !tick_ready)
    else $error("tick accepted too soon after the previous one");

  // a fresh sample is loaded only while a tick is being worked on
  a_sample_origin: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(!tick_ready))
    else $error("sample appeared without a tick in progress");

  // a stalled sample stays put
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_sample))
    else $error("stalled sample changed or dropped");

  // register writes never stall
  a_cfg_ready: assert property (@(posedge clk) disable iff (rst)
    cfg_ready)
    else $error("register write channel not ready");

endmodule

bind multi_waveform_oscillator mwo_checker u_mwo_checker (
  .clk        (clk),
  .rst        (rst),
  .tick_valid (tick.valid),
  .tick_ready (tick.ready),
  .out_valid  (samples.valid),
  .out_ready  (samples.ready),
  .out_sample (samples.sample),
  .cfg_ready  (cfg.ready)
);

FILE: tb/multi_waveform_oscillator_test.sv
// ----------------------------------------------------------------------------
// multi_waveform_oscillator_test - self-checking bench for the dds oscillator
// drives tick items with random gaps, collects sample items under random back
// pressure and checks each one against an in-bench oscillator model, across
// directed register settings followed by randomised phases
// ----------------------------------------------------------------------------
module multi_waveform_oscillator_test;
  import mwo_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_TICKS  = 850;
  localparam int LONG_HOLD     = 200;    // cycles the sink holds off in a stall
  localparam int SETTLE_CYCLES = 64;     // well over the triangle path, the longest one
  localparam int CYCLE_LIMIT   = 500000;

  localparam logic [31:0] QUARTER_TURN = 32'h4000_0000;

  // nested series divisors, innermost term first (entry 0 is 210)
  localparam logic [6:0][7:0] SERIES_DIV =
    {8'd6, 8'd20, 8'd42, 8'd72, 8'd110, 8'd156, 8'd210};

  // duty values around the clamp limits and the half point
  localparam logic [9:0][15:0] DUTY_EDGES =
    {16'd0, 16'd65, 16'd66, 16'd67, 16'd32767,
     16'd32768, 16'd65469, 16'd65470, 16'd65471, 16'd65535};

  typedef struct {
    logic        clear;
    int unsigned gap;
  } tick_item_t;

  // clock and all block inputs start at known values
  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                  tick_valid  = 1'b0;
  logic                  tick_clear  = 1'b0;
  logic                  sample_ready = 1'b0;
  logic                  cfg_valid   = 1'b0;
  logic [REG_IDX_W-1:0]  cfg_index   = '0;
  logic [REG_DATA_W-1:0] cfg_data    = '0;

  mwo_tick_if   tick_ch ();
  mwo_sample_if sample_ch ();
  mwo_cfg_if    cfg_ch ();

  assign tick_ch.valid       = tick_valid;
  assign tick_ch.clear_phase = tick_clear;
  assign sample_ch.ready     = sample_ready;
  assign cfg_ch.valid        = cfg_valid;
  assign cfg_ch.index        = cfg_index;
  assign cfg_ch.data         = cfg_data;

  multi_waveform_oscillator u_dut (
    .clk     (clk),
    .rst     (rst),
    .tick    (tick_ch),
    .samples (sample_ch),
    .cfg     (cfg_ch)
  );

  // oscillator model: registers and state as the block holds them
  logic [WAVE_W-1:0]   osc_wave;
  logic [STEP_W-1:0]   osc_step;
  logic [DUTY_W-1:0]   osc_duty;
  logic [SAMPLE_W-1:0] osc_dc;
  logic [31:0]         osc_phase;
  logic [31:0]         osc_lfsr;
  int                  quarter_sine [MWO_SINE_DEPTH];

  // stimulus and scoreboard
  tick_item_t                 tick_q [$];
  tick_item_t                 next_tick;
  logic signed [SAMPLE_W-1:0] expected_samples [$];
  logic signed [SAMPLE_W-1:0] wanted;
  int unsigned                ticks_pushed   = 0;
  int unsigned                ticks_accepted = 0;
  int unsigned                tick_wait      = 0;
  int unsigned                sink_wait      = 0;
  int unsigned                hold_left      = 0;
  int unsigned                stall_requests = 0;
  int unsigned                stall_served   = 0;
  logic                       sink_idle      = 1'b0;
  int unsigned                errors         = 0;
  int unsigned                cycle_count    = 0;

  // q1.23 value of sin(pi/2 * (idx + 0.5) / depth), fixed-point series
  function automatic int quarter_sine_value(input int unsigned idx);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] t;
    logic [63:0] s;
    x  = HALF_PI_Q30 * (2 * idx + 1) / (2 * MWO_SINE_DEPTH);
    x2 = (x * x) >> 30;
    t  = ONE_Q30;
    for (int n = 0; n < 7; n++) begin
      t = ONE_Q30 - ((x2 * t) >> 30) / 64'(SERIES_DIV[n]);
    end
    s = (x * t) >> 30;
    s = (s + 64'd64) >> 7;
    if (s > 64'd8388607) begin
      s = 64'd8388607;
    end
    return int'(s[SAMPLE_W-1:0]);
  endfunction

  // advance the model by one tick and give the sample it should produce
  function automatic logic signed [SAMPLE_W-1:0] next_sample(input logic clear);
    logic [DUTY_W-1:0] duty;
    logic [31:0]       lookup;
    logic [63:0]       k;
    logic [63:0]       p;
    logic [63:0]       d;
    logic [63:0]       len;
    logic [63:0]       q;
    logic              lsb;
    longint            v;
    if (clear) begin
      osc_phase = '0;
    end
    osc_phase = osc_phase + osc_step;

    // duty is stored raw and clamped only where it is used
    duty = osc_duty;
    if (duty < DUTY_MIN) begin
      duty = DUTY_MIN;
    end
    if (duty > DUTY_MAX) begin
      duty = DUTY_MAX;
    end
    p = {32'b0, osc_phase};
    d = {32'b0, duty, 16'b0};
    v = 0;

    case (osc_wave)
      WAVE_SINE, WAVE_COSINE: begin
        lookup = (osc_wave == WAVE_COSINE) ? osc_phase + QUARTER_TURN : osc_phase;
        k = ({34'b0, lookup[29:0]} * MWO_SINE_DEPTH) >> 30;
        // odd quadrants run the table backwards, the upper half is negated
        if (lookup[30]) begin
          k = MWO_SINE_DEPTH - 1 - k;
        end
        v = quarter_sine[k];
        if (lookup[31]) begin
          v = -v;
        end
      end
      WAVE_TRIANGLE: begin
        // falls over 1-duty, rises over duty, rounding half up
        len = 64'h1_0000_0000 - d;
        if (p <= len) begin
          q = ((p << 24) + (len >> 1)) / len;
          v = 64'sd8388608 - longint'(q);
        end else begin
          q = (((p - len) << 24) + (d >> 1)) / d;
          v = longint'(q) - 64'sd8388608;
        end
      end
      WAVE_SQUARE: begin
        v = (p < d) ? 64'sd8388607 : -64'sd8388608;
      end
      WAVE_SAWTOOTH: begin
        v = longint'(osc_phase[31:8]) - 64'sd8388608;
        // inverted ramp below half duty
        if (duty < DUTY_HALF) begin
          v = -v;
        end
      end
      WAVE_DC: begin
        v = longint'($signed(osc_dc));
      end
      WAVE_NOISE: begin
        // galois lfsr steps only on noise ticks
        lsb      = osc_lfsr[0];
        osc_lfsr = osc_lfsr >> 1;
        if (lsb) begin
          osc_lfsr = osc_lfsr ^ LFSR_MASK;
        end
        v = longint'($signed(osc_lfsr[SAMPLE_W-1:0]));
      end
      default: begin
        v = 0;
      end
    endcase

    // +1.0 (and anything beyond) saturates
    if (v > Q23_MAX) begin
      v = Q23_MAX;
    end
    if (v < Q23_MIN) begin
      v = Q23_MIN;
    end
    return v[SAMPLE_W-1:0];
  endfunction

  // one register write over the config channel, model updated on acceptance
  task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [31:0] value);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_valid <= 1'b0;
    case (idx)
      REG_WAVE_SELECT: osc_wave = value[WAVE_W-1:0];
      REG_PHASE_STEP:  osc_step = value[STEP_W-1:0];
      REG_DUTY:        osc_duty = value[DUTY_W-1:0];
      REG_DC_LEVEL:    osc_dc   = value[SAMPLE_W-1:0];
      default: ;
    endcase
  endtask

  task automatic set_regs(input logic [31:0] wave, input logic [31:0] step,
                          input logic [31:0] duty, input logic [31:0] dc);
    write_reg(REG_WAVE_SELECT, wave);
    write_reg(REG_PHASE_STEP, step);
    write_reg(REG_DUTY, duty);
    write_reg(REG_DC_LEVEL, dc);
  endtask

  task automatic push_tick(input logic clear, input int unsigned gap);
    tick_item_t it;
    it.clear = clear;
    it.gap   = gap;
    tick_q.push_back(it);
    ticks_pushed++;
  endtask

  // every pushed tick taken and every sample back: the block is idle
  task automatic wait_drained();
    while (ticks_accepted != ticks_pushed || expected_samples.size() != 0) begin
      @(posedge clk);
    end
  endtask

  // free-running clock
  initial begin
    forever #2 clk = ~clk;
  end

  // cycle limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: run did not complete within %0d cycles", $time, CYCLE_LIMIT);
      $display("FAIL");
      $finish;
    end
  end

  // tick driver: each item waits out its own gap before it is offered
  always @(posedge clk) begin
    if (rst) begin
      tick_valid <= 1'b0;
      tick_wait = 0;
    end else begin
      if (tick_valid && tick_ch.ready) begin
        expected_samples.push_back(next_sample(tick_clear));
        ticks_accepted++;
      end
      // only move on once the current item has gone (or none is offered)
      if (!tick_valid || tick_ch.ready) begin
        if (tick_q.size() != 0 && tick_wait >= tick_q[0].gap) begin
          next_tick = tick_q.pop_front();
          tick_valid <= 1'b1;
          tick_clear <= next_tick.clear;
          tick_wait = 0;
        end else begin
          tick_valid <= 1'b0;
          if (tick_q.size() != 0) begin
            tick_wait++;
          end
        end
      end
    end
  end

  // sample monitor and sink: random back pressure plus requested long holds
  always @(posedge clk) begin
    if (rst) begin
      sample_ready <= 1'b0;
    end else begin
      if (sample_ch.valid && sample_ready) begin
        if (expected_samples.size() == 0) begin
          $display("%0t: sample %0d with no tick outstanding", $time, sample_ch.sample);
          errors++;
        end else begin
          wanted = expected_samples.pop_front();
          if (sample_ch.sample !== wanted) begin
            $display("%0t: sample mismatch, expected %0d, got %0d",
                     $time, wanted, sample_ch.sample);
            errors++;
          end
        end
        sink_wait = sink_idle ? $urandom_range(0, 19) : 0;
      end
      // a new stall request starts a long hold counted here
      if (stall_served != stall_requests) begin
        stall_served = stall_requests;
        hold_left    = LONG_HOLD;
      end
      if (hold_left != 0) begin
        hold_left--;
        sample_ready <= 1'b0;
      end else if (sink_wait != 0) begin
        sink_wait--;
        sample_ready <= 1'b0;
      end else begin
        sample_ready <= 1'b1;
      end
    end
  end

  // stimulus sequence
  initial begin : stimulus
    int unsigned random_ticks;
    int unsigned phase_no;
    int unsigned n;
    int unsigned pause_at;
    int unsigned pick;
    logic        sender_idle;
    logic [31:0] value;

    // model reset state, sine table built up front
    osc_wave  = WAVE_SINE;
    osc_step  = '0;
    osc_duty  = DUTY_RESET;
    osc_dc    = '0;
    osc_phase = '0;
    osc_lfsr  = LFSR_RESET;
    for (int i = 0; i < MWO_SINE_DEPTH; i++) begin
      quarter_sine[i] = quarter_sine_value(i);
    end

    repeat (4) @(posedge clk);
    rst <= 1'b0;
    sink_idle = 1'b1;

    // --- directed part ---

    // reset settings: sine with a zero step stays at phase zero
    push_tick(1'b0, 0);
    push_tick(1'b1, 3);
    wait_drained();

    // sine through all four quadrants
    set_regs({29'b0, WAVE_SINE}, 32'h3FF0_0000, 32'd32768, 32'd0);
    repeat (4) push_tick(1'b0, $urandom_range(0, 19));
    wait_drained();

    // cosine, full-scale step, spare register bits set
    set_regs({29'h1FFF_FFFF, WAVE_COSINE}, 32'hFFFF_FFFF, 32'hFFFF_8000, 32'd0);
    push_tick(1'b1, 0);
    push_tick(1'b0, 0);
    wait_drained();

    // triangle at half duty: phase exactly on the turning point, then zero
    set_regs({29'b0, WAVE_TRIANGLE}, 32'h8000_0000, 32'd32768, 32'd0);
    push_tick(1'b1, 0);
    push_tick(1'b0, 0);
    wait_drained();

    // triangle with duty below the clamp range
    set_regs({29'b0, WAVE_TRIANGLE}, 32'h1234_5678, 32'd0, 32'd0);
    push_tick(1'b0, 0);
    push_tick(1'b0, 0);
    wait_drained();

    // triangle with duty above the clamp range
    write_reg(REG_DUTY, 32'd65535);
    push_tick(1'b0, 0);
    wait_drained();

    // square, top duty
    set_regs({29'b0, WAVE_SQUARE}, 32'h8000_0000, 32'd65535, 32'd0);
    push_tick(1'b1, 0);
    push_tick(1'b0, 0);
    wait_drained();

    // inverted sawtooth (duty under one half)
    set_regs({29'b0, WAVE_SAWTOOTH}, 32'hFFFF_FFFF, 32'd100, 32'd0);
    push_tick(1'b0, 0);
    push_tick(1'b0, 0);
    wait_drained();

    // inverted sawtooth at phase zero: +1.0 saturates
    set_regs({29'b0, WAVE_SAWTOOTH}, 32'd0, 32'd0, 32'd0);
    push_tick(1'b1, 0);
    wait_drained();

    // dc at both extremes, upper data bits ignored
    set_regs({29'b0, WAVE_DC}, 32'd0, 32'd32768, 32'hFF80_0000);
    push_tick(1'b0, 0);
    wait_drained();
    write_reg(REG_DC_LEVEL, 32'h007F_FFFF);
    push_tick(1'b0, 0);
    wait_drained();

    // noise, then silent (lfsr must hold), then noise again
    write_reg(REG_WAVE_SELECT, {29'b0, WAVE_NOISE});
    push_tick(1'b0, 0);
    push_tick(1'b0, 0);
    wait_drained();
    write_reg(REG_WAVE_SELECT, 32'hFFFF_FFFF);
    push_tick(1'b0, 0);
    wait_drained();
    write_reg(REG_WAVE_SELECT, {29'b0, WAVE_NOISE});
    push_tick(1'b0, 0);
    push_tick(1'b0, 0);
    wait_drained();

    // --- random phases ---
    random_ticks = 0;
    phase_no     = 0;
    while (random_ticks < RANDOM_TICKS) begin
      // registers: most phases rewrite most of them
      if ($urandom_range(0, 3) != 0) begin
        write_reg(REG_WAVE_SELECT, $urandom());
      end
      if ($urandom_range(0, 3) != 0) begin
        pick = $urandom_range(0, 9);
        if (pick < 3) begin
          value = $urandom();
        end else if (pick < 5) begin
          value = $urandom_range(0, 4095);
        end else if (pick < 6) begin
          value = 32'd0;
        end else if (pick < 7) begin
          value = 32'hFFFF_FFFF - $urandom_range(0, 4095);
        end else begin
          value = 32'd1 << $urandom_range(0, 31);
        end
        write_reg(REG_PHASE_STEP, value);
      end
      if ($urandom_range(0, 3) != 0) begin
        value = $urandom();
        if ($urandom_range(0, 2) == 0) begin
          value[15:0] = DUTY_EDGES[$urandom_range(0, 9)];
        end
        write_reg(REG_DUTY, value);
      end
      if ($urandom_range(0, 3) != 0) begin
        write_reg(REG_DC_LEVEL, $urandom());
      end

      // idling per phase: none, sender only, sink only, or both
      pick        = $urandom_range(0, 3);
      sender_idle = pick[0];
      sink_idle   = pick[1];
      n           = $urandom_range(8, 40);

      // long sink hold with the sender pressing on, first phase always
      if (phase_no == 0 || $urandom_range(0, 9) == 0) begin
        sender_idle = 1'b0;
        n           = 40;
        stall_requests++;
      end

      // sender pause mid-phase until the block has drained
      pause_at = n;
      if (phase_no == 1 || $urandom_range(0, 5) == 0) begin
        pause_at = $urandom_range(1, n - 1);
      end

      for (int i = 0; i < n; i++) begin
        if (i == pause_at) begin
          wait_drained();
        end
        push_tick($urandom_range(0, 9) == 0, sender_idle ? $urandom_range(0, 19) : 0);
      end
      random_ticks += n;
      wait_drained();
      phase_no++;
    end

    // let any straggler show up before the verdict
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (expected_samples.size() != 0) begin
      $display("%0t: %0d samples never arrived", $time, expected_samples.size());
    end
    if (errors == 0 && expected_samples.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

FILE: sim.f
rtl/mwo_pkg.sv
rtl/mwo_if.sv
rtl/multi_waveform_oscillator.sv
rtl/mwo_checker.sv
tb/multi_waveform_oscillator_test.sv
